>>> sv/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg: shared types and constants for the length-prefixed frame deframer
// Phase, byte class and error codes, field widths and the result word layout.
// ----------------------------------------------------------------------------
package lpfd_pkg;

   // base header is always eight bytes: size(4) opcode(2) offset(1) flag(1)
   localparam int unsigned BASE_BYTES        = 8;
   localparam int unsigned HDR_UNIT_BYTES_DEF = 4;
   localparam logic [7:0]  OFFSET_RESET      = 8'd2;
   localparam logic [31:0] MAX_FRAME_RESET   = 32'd1048576;

   localparam int unsigned SIZE_W  = 32;
   localparam int unsigned OPC_W   = 16;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned POS_W   = 32;
   localparam int unsigned RSP_DATA_W = 112;  // 107 field bits, padded to bytes

   // base header byte positions
   localparam logic [2:0] BIDX_SIZE0  = 3'd0;
   localparam logic [2:0] BIDX_SIZE1  = 3'd1;
   localparam logic [2:0] BIDX_SIZE2  = 3'd2;
   localparam logic [2:0] BIDX_SIZE3  = 3'd3;
   localparam logic [2:0] BIDX_OPC_HI = 3'd4;
   localparam logic [2:0] BIDX_OPC_LO = 3'd5;
   localparam logic [2:0] BIDX_OFFSET = 3'd6;
   localparam logic [2:0] BIDX_FLAG   = 3'd7;

   typedef enum logic [1:0] {
      PH_BASE = 2'd0,
      PH_EXT  = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      CLS_BASE = 2'd0,
      CLS_EXT  = 2'd1,
      CLS_BODY = 2'd2
   } class_type;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_OFFSET = 2'd1,
      ERR_SIZE   = 2'd2
   } err_type;

   typedef struct packed {
      class_type          byte_class;
      logic [BYTE_W-1:0]  data_byte;
      logic [SIZE_W-1:0]  frame_size;
      logic [OPC_W-1:0]   opcode;
      logic [BYTE_W-1:0]  offset_words;
      logic [BYTE_W-1:0]  flag_bits;
      logic [POS_W-1:0]   body_position;
      logic               header_done;
      logic               frame_end;
      err_type            error_code;
   } rsp_type;

endpackage

>>> sv/length_prefixed_frame_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer: byte stream to classified frame bytes
// Splits a byte stream into frames with a big-endian length-prefixed header.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while req_tready is high and returns one
// registered result word per byte. Each result classes the byte (base header,
// extension header, body), carries the decoded size, opcode, offset and flag
// of the current frame, the body position, and marks for the last header byte
// and the last frame byte (tlast). A bad offset (below 2), a size below the
// header length or a size above csr max_frame_bytes is reported in error_code
// on the eighth base byte, and the next byte starts a new header. The
// sustained rate is one byte per cycle without output stalls: the header
// fields, the lengths derived from them and the byte counter are all updated
// in a single pass. A two-entry output register lets one more byte in while a
// result waits, then holds req_tready low until the stalled word leaves.
// Write csr only while no byte is in flight.
module length_prefixed_frame_deframer #(
   parameter int unsigned HEADER_UNIT_BYTES = lpfd_pkg::HDR_UNIT_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // input byte stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] rx_byte
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] data_byte, [39:8] frame_size, [55:40] opcode, [63:56] offset_words,
   // [71:64] flag_bits, [103:72] body_position, [104] header_done,
   // [106:105] error_code, [111:107] zero
   output logic [lpfd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [1:0]                       rsp_tuser,   // [1:0] byte_class
   output logic                             rsp_tlast,   // frame_end
   // max_frame_bytes write port
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [31:0]                      csr_data
);
   import lpfd_pkg::*;

   // header length in bytes: offset times unit, needs room for the product
   localparam int unsigned HdrW = BYTE_W + $clog2(HEADER_UNIT_BYTES + 1);

   logic [31:0]       max_frame_ff;
   phase_type         phase_ff, phase_in;
   logic [POS_W-1:0]  count_ff, count_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [OPC_W-1:0]  opcode_ff, opcode_in;
   logic [BYTE_W-1:0] offset_ff, offset_in;
   logic [BYTE_W-1:0] flag_ff, flag_in;
   logic [HdrW-1:0]   ext_len_ff, ext_len_in;
   logic [SIZE_W-1:0] body_len_ff, body_len_in;

   logic [HdrW-1:0]   hdr_raw;
   logic [HdrW-1:0]   hdr_len;
   logic [2:0]        base_idx;
   rsp_type           res;

   rsp_type           out_ff, skid_ff;
   logic              out_valid_ff, skid_valid_ff;
   logic              accept, pop;

   assign csr_ready  = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   // capture the frame size limit
   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff <= MAX_FRAME_RESET;
      end else if (csr_valid && csr_ready) begin
         max_frame_ff <= csr_data;
      end
   end

   // header length from the stored offset, never below the base header
   assign hdr_raw  = HdrW'(offset_ff) * HdrW'(HEADER_UNIT_BYTES);
   assign hdr_len  = (hdr_raw < HdrW'(BASE_BYTES)) ? HdrW'(BASE_BYTES) : hdr_raw;
   assign base_idx = count_ff[2:0];

   // decode one byte: next state and its result word
   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      size_in     = size_ff;
      opcode_in   = opcode_ff;
      offset_in   = offset_ff;
      flag_in     = flag_ff;
      ext_len_in  = ext_len_ff;
      body_len_in = body_len_ff;

      res               = '0;
      res.data_byte     = req_tdata;
      res.byte_class    = CLS_BASE;
      res.error_code    = ERR_NONE;

      case (phase_ff)
         PH_EXT: begin
            res.byte_class = CLS_EXT;
            count_in = count_ff + POS_W'(1);
            if (count_in >= POS_W'(ext_len_ff)) begin
               res.header_done = 1'b1;
               count_in = '0;
               if (body_len_ff == '0) begin
                  res.frame_end = 1'b1;
                  phase_in = PH_BASE;
               end else begin
                  phase_in = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            res.byte_class = CLS_BODY;
            count_in = count_ff + POS_W'(1);
            res.body_position = count_in;
            if (count_in >= body_len_ff) begin
               res.frame_end = 1'b1;
               phase_in = PH_BASE;
               count_in = '0;
            end
         end
         default: begin
            // shift the byte into its base header field
            case (base_idx)
               BIDX_SIZE0: begin
                  opcode_in = '0;
                  offset_in = OFFSET_RESET;
                  flag_in   = '0;
                  size_in   = SIZE_W'(req_tdata);
               end
               BIDX_SIZE1, BIDX_SIZE2, BIDX_SIZE3: begin
                  size_in = {size_ff[SIZE_W-9:0], req_tdata};
               end
               BIDX_OPC_HI: opcode_in = {req_tdata, 8'h00};
               BIDX_OPC_LO: opcode_in = {opcode_ff[15:8], req_tdata};
               BIDX_OFFSET: offset_in = req_tdata;
               BIDX_FLAG:   flag_in   = req_tdata;
               default:     flag_in   = flag_ff;
            endcase
            phase_in = PH_BASE;
            if (base_idx != BIDX_FLAG) begin
               count_in = POS_W'(base_idx) + POS_W'(1);
            end else begin
               // last base byte: check the header and pick the next phase
               count_in    = '0;
               ext_len_in  = hdr_len - HdrW'(BASE_BYTES);
               body_len_in = size_ff - SIZE_W'(hdr_len);
               if (offset_ff < OFFSET_RESET) begin
                  res.error_code = ERR_OFFSET;
               end else if (size_ff < SIZE_W'(hdr_len) || size_ff > max_frame_ff) begin
                  res.error_code = ERR_SIZE;
               end else if (hdr_len > HdrW'(BASE_BYTES)) begin
                  phase_in = PH_EXT;
               end else begin
                  res.header_done = 1'b1;
                  if (size_ff == SIZE_W'(hdr_len)) begin
                     res.frame_end = 1'b1;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
         end
      endcase

      res.frame_size   = size_in;
      res.opcode       = opcode_in;
      res.offset_words = offset_in;
      res.flag_bits    = flag_in;
   end

   // phase register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BASE;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

   // header fields and byte counter
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         size_ff     <= '0;
         opcode_ff   <= '0;
         offset_ff   <= OFFSET_RESET;
         flag_ff     <= '0;
         ext_len_ff  <= '0;
         body_len_ff <= '0;
      end else if (accept) begin
         count_ff    <= count_in;
         size_ff     <= size_in;
         opcode_ff   <= opcode_in;
         offset_ff   <= offset_in;
         flag_ff     <= flag_in;
         ext_len_ff  <= ext_len_in;
         body_len_ff <= body_len_in;
      end
   end

   // two-entry result register: skid holds a word while the output stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (pop) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (accept) begin
            if (!out_valid_ff || pop) begin
               out_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_ff <= res;
         end else begin
            skid_ff <= res;
         end
      end
   end

   // pack the result word onto the ports
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.byte_class;
   assign rsp_tlast  = out_ff.frame_end;
   assign rsp_tdata  = {5'b00000, out_ff.error_code, out_ff.header_done,
                        out_ff.body_position, out_ff.flag_bits, out_ff.offset_words,
                        out_ff.opcode, out_ff.frame_size, out_ff.data_byte};

   // a word waits in the skid stage only behind a held output word
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held with no output word");

   // the base header counter never leaves the eight base byte positions
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BASE) |-> (count_ff < POS_W'(BASE_BYTES)))
      else $error("base header counter out of range");

   // a frame never ends on a rejected header
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (out_ff.error_code == ERR_NONE))
      else $error("frame end reported together with an error");

   // header done never lands on a body byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.header_done) |-> (out_ff.byte_class != CLS_BODY))
      else $error("header done on a body byte");

endmodule
